>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the handle table RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg
// Commands, status codes and widths shared by the handle table files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ght_pkg;

    localparam int HANDLE_W             = 32;
    localparam int CMD_W                = 2;
    localparam int STATUS_W             = 2;
    localparam int SLOT_INDEX_BITS_DEF  = 12;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DEAD = 2'd2;

endpackage

`default_nettype wire

>>> rtl/ght_req_if.sv
// ----------------------------------------------------------------------------
// ght_req_if
// Command channel: valid/ready handshake with command and handle payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ght_req_if;

    logic                          valid;
    logic                          ready;
    logic [ght_pkg::CMD_W-1:0]     command;
    logic [ght_pkg::HANDLE_W-1:0]  handle_in;

    modport source (output valid, output command, output handle_in, input ready);
    modport sink   (input valid, input command, input handle_in, output ready);

endinterface

`default_nettype wire

>>> rtl/ght_rsp_if.sv
// ----------------------------------------------------------------------------
// ght_rsp_if
// Result channel: valid/ready handshake with one result item per command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ght_rsp_if #(
    parameter int SLOT_INDEX_BITS = ght_pkg::SLOT_INDEX_BITS_DEF
);

    logic                            valid;
    logic                            ready;
    logic [ght_pkg::STATUS_W-1:0]    status;
    logic [ght_pkg::HANDLE_W-1:0]    handle_out;
    logic [SLOT_INDEX_BITS-1:0]      dense_position;
    logic [SLOT_INDEX_BITS-1:0]      moved_from;
    logic                            is_live;
    logic [SLOT_INDEX_BITS:0]        live_total;

    modport source (
        output valid, output status, output handle_out, output dense_position,
        output moved_from, output is_live, output live_total, input ready
    );
    modport sink (
        input valid, input status, input handle_out, input dense_position,
        input moved_from, input is_live, input live_total, output ready
    );

endinterface

`default_nettype wire

>>> rtl/ght_ram.sv
// ----------------------------------------------------------------------------
// ght_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ght_ram #(
    parameter int WIDTH     = 32,
    parameter int ADDR_BITS = 12
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [2**ADDR_BITS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/generational_handle_table.sv
// ----------------------------------------------------------------------------
// generational_handle_table
// Slot map with generational handles, FIFO free list and a packed dense array.
//
//   channel | dir | payload                                          | handshake
//   req     | in  | command, handle_in                               | valid/ready
//   rsp     | out | status, handle_out, dense_position, moved_from,  | valid/ready
//           |     | is_live, live_total                              |
//
// Add and lookup pass through one working state (S_ADD, S_CHK) before S_DONE
// (an add on a full table goes to S_DONE directly); a live remove steps through
// S_CHK, S_MOV, S_FREE and S_LINK and makes up to three dependent slot writes
// through the single write port of the slot RAM, and a remove of a handle that
// is not live ends after S_CHK. Clear sweeps the slot RAM, one slot entry per
// cycle. After reset the slot RAM is initialized by the same pass before the first command transfer.
// A finished result waits in the output register; a new command is taken
// meanwhile, and the next result holds until the output register drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module generational_handle_table #(
    parameter int SLOT_INDEX_BITS = ght_pkg::SLOT_INDEX_BITS_DEF
) (
    input wire logic   clk,
    input wire logic   rst_n,
    ght_req_if.sink    req,
    ght_rsp_if.source  rsp
);

    localparam int IDX_W = SLOT_INDEX_BITS;
    localparam int CNT_W = SLOT_INDEX_BITS + 1;
    localparam int HW    = ght_pkg::HANDLE_W;
    localparam int SW    = ght_pkg::STATUS_W;

    localparam logic [CNT_W-1:0] CAP_C    = {1'b1, {IDX_W{1'b0}}};
    localparam logic [HW-1:0]    GEN_STEP = HW'(1) << SLOT_INDEX_BITS;

    localparam logic [2:0] S_SWEEP = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ADD   = 3'd2;
    localparam logic [2:0] S_CHK   = 3'd3;
    localparam logic [2:0] S_MOV   = 3'd4;
    localparam logic [2:0] S_FREE  = 3'd5;
    localparam logic [2:0] S_LINK  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    typedef struct packed {
        logic [HW-1:0]    handle;
        logic [CNT_W-1:0] pos;
        logic [CNT_W-1:0] next_free;
    } slot_t;

    // control state
    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] sweep_reg, sweep_next;
    logic             clr_emit_reg, clr_emit_next;
    logic [CNT_W-1:0] live_reg, live_next;
    logic [CNT_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic             out_valid_reg, out_valid_next;

    // per-command working registers
    logic [ght_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic [HW-1:0]             h_reg, h_next;
    logic [IDX_W-1:0]          last_reg, last_next;
    logic                      full_reg, full_next;
    logic [IDX_W-1:0]          pos_reg, pos_next;
    logic [IDX_W-1:0]          mov_reg, mov_next;
    slot_t                     ent_reg, ent_next;

    // pending result
    logic [SW-1:0]    res_status_reg, res_status_next;
    logic [HW-1:0]    res_handle_reg, res_handle_next;
    logic [IDX_W-1:0] res_dpos_reg, res_dpos_next;
    logic [IDX_W-1:0] res_mfrom_reg, res_mfrom_next;
    logic             res_live_reg, res_live_next;

    // output register
    logic [SW-1:0]    out_status_reg;
    logic [HW-1:0]    out_handle_reg;
    logic [IDX_W-1:0] out_dpos_reg;
    logic [IDX_W-1:0] out_mfrom_reg;
    logic             out_live_reg;
    logic [CNT_W-1:0] out_total_reg;
    logic             load_out;

    // memory ports
    logic             slot_we;
    logic [IDX_W-1:0] slot_waddr, slot_raddr;
    slot_t            slot_wdata, slot_rdata;
    logic             dense_we;
    logic [IDX_W-1:0] dense_waddr, dense_raddr;
    logic [HW-1:0]    dense_wdata, dense_rdata;

    logic             accept;
    logic             alive;
    logic [IDX_W-1:0] h_idx;
    logic [HW-1:0]    new_handle;

    ght_ram #(
        .WIDTH     ($bits(slot_t)),
        .ADDR_BITS (IDX_W)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    ght_ram #(
        .WIDTH     (HW),
        .ADDR_BITS (IDX_W)
    ) u_dense_ram (
        .clk   (clk),
        .we    (dense_we),
        .waddr (dense_waddr),
        .wdata (dense_wdata),
        .raddr (dense_raddr),
        .rdata (dense_rdata)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign h_idx     = h_reg[IDX_W-1:0];
    assign alive     = (slot_rdata.handle == h_reg) && !slot_rdata.pos[IDX_W];
    assign new_handle = slot_rdata.handle + GEN_STEP;

    always_comb
    begin
        state_next      = state_reg;
        sweep_next      = sweep_reg;
        clr_emit_next   = clr_emit_reg;
        live_next       = live_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        cmd_next        = cmd_reg;
        h_next          = h_reg;
        last_next       = last_reg;
        full_next       = full_reg;
        pos_next        = pos_reg;
        mov_next        = mov_reg;
        ent_next        = ent_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        res_dpos_next   = res_dpos_reg;
        res_mfrom_next  = res_mfrom_reg;
        res_live_next   = res_live_reg;
        load_out        = 1'b0;

        slot_we     = 1'b0;
        slot_waddr  = '0;
        slot_wdata  = '0;
        slot_raddr  = '0;
        dense_we    = 1'b0;
        dense_waddr = '0;
        dense_wdata = '0;
        dense_raddr = live_reg[IDX_W-1:0] - IDX_W'(1);

        case (state_reg)
            S_SWEEP:
            begin
                slot_we    = 1'b1;
                slot_waddr = sweep_reg;
                slot_wdata = '{handle: HW'(sweep_reg), pos: CAP_C,
                               next_free: CNT_W'(sweep_reg) + CNT_W'(1)};
                sweep_next = sweep_reg + IDX_W'(1);
                if (sweep_reg == '1)
                begin
                    clr_emit_next = 1'b0;
                    if (clr_emit_reg)
                    begin
                        res_status_next = ght_pkg::ST_OK;
                        res_handle_next = h_reg;
                        res_dpos_next   = '0;
                        res_mfrom_next  = '0;
                        res_live_next   = 1'b0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_IDLE:
            begin
                slot_raddr = (req.command == ght_pkg::CMD_ADD) ? head_reg[IDX_W-1:0]
                                                               : req.handle_in[IDX_W-1:0];
                if (accept)
                begin
                    cmd_next  = req.command;
                    h_next    = req.handle_in;
                    last_next = live_reg[IDX_W-1:0] - IDX_W'(1);
                    full_next = (live_reg == CAP_C);
                    case (req.command)
                        ght_pkg::CMD_ADD:
                        begin
                            if (live_reg == CAP_C)
                            begin
                                res_status_next = ght_pkg::ST_FULL;
                                res_handle_next = '0;
                                res_dpos_next   = '0;
                                res_mfrom_next  = '0;
                                res_live_next   = 1'b0;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_ADD;
                            end
                        end
                        ght_pkg::CMD_REMOVE, ght_pkg::CMD_LOOKUP:
                        begin
                            state_next = S_CHK;
                        end
                        ght_pkg::CMD_CLEAR:
                        begin
                            live_next     = '0;
                            head_next     = '0;
                            tail_next     = '1;
                            sweep_next    = '0;
                            clr_emit_next = 1'b1;
                            state_next    = S_SWEEP;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_ADD:
            begin
                // pop the free head, bump its generation, append to the dense array
                slot_we     = 1'b1;
                slot_waddr  = head_reg[IDX_W-1:0];
                slot_wdata  = '{handle: new_handle, pos: {1'b0, live_reg[IDX_W-1:0]},
                                next_free: slot_rdata.next_free};
                dense_we    = 1'b1;
                dense_waddr = live_reg[IDX_W-1:0];
                dense_wdata = new_handle;
                head_next   = slot_rdata.next_free;
                live_next   = live_reg + CNT_W'(1);
                res_status_next = ght_pkg::ST_OK;
                res_handle_next = new_handle;
                res_dpos_next   = live_reg[IDX_W-1:0];
                res_mfrom_next  = '0;
                res_live_next   = 1'b0;
                state_next      = S_DONE;
            end

            S_CHK:
            begin
                res_handle_next = h_reg;
                res_mfrom_next  = '0;
                res_live_next   = 1'b0;
                res_dpos_next   = '0;
                res_status_next = ght_pkg::ST_DEAD;
                state_next      = S_DONE;
                if (alive)
                begin
                    if (cmd_reg == ght_pkg::CMD_LOOKUP)
                    begin
                        res_status_next = ght_pkg::ST_OK;
                        res_dpos_next   = slot_rdata.pos[IDX_W-1:0];
                        res_live_next   = 1'b1;
                    end
                    else
                    begin
                        // fill the gap with the last dense entry, fetch its slot
                        ent_next    = slot_rdata;
                        pos_next    = slot_rdata.pos[IDX_W-1:0];
                        mov_next    = dense_rdata[IDX_W-1:0];
                        dense_we    = 1'b1;
                        dense_waddr = slot_rdata.pos[IDX_W-1:0];
                        dense_wdata = dense_rdata;
                        slot_raddr  = dense_rdata[IDX_W-1:0];
                        state_next  = S_MOV;
                    end
                end
            end

            S_MOV:
            begin
                // repoint the moved entry unless it is the one being removed
                if (mov_reg != h_idx)
                begin
                    slot_we    = 1'b1;
                    slot_waddr = mov_reg;
                    slot_wdata = '{handle: slot_rdata.handle, pos: {1'b0, pos_reg},
                                   next_free: slot_rdata.next_free};
                end
                slot_raddr = tail_reg;
                state_next = S_FREE;
            end

            S_FREE:
            begin
                // link the freed slot behind the current tail unless the table was full
                if (!full_reg)
                begin
                    slot_we    = 1'b1;
                    slot_waddr = tail_reg;
                    slot_wdata = '{handle: slot_rdata.handle, pos: slot_rdata.pos,
                                   next_free: {1'b0, h_idx}};
                end
                state_next = S_LINK;
            end

            S_LINK:
            begin
                slot_we    = 1'b1;
                slot_waddr = h_idx;
                slot_wdata = '{handle: ent_reg.handle, pos: CAP_C, next_free: CAP_C};
                live_next  = live_reg - CNT_W'(1);
                if (full_reg)
                begin
                    head_next = {1'b0, h_idx};
                end
                tail_next       = h_idx;
                res_status_next = ght_pkg::ST_OK;
                res_handle_next = h_reg;
                res_dpos_next   = pos_reg;
                res_mfrom_next  = last_reg;
                res_live_next   = 1'b0;
                state_next      = S_DONE;
            end

            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = (out_valid_reg && !rsp.ready) || load_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            sweep_reg     <= '0;
            clr_emit_reg  <= 1'b0;
            live_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            clr_emit_reg  <= clr_emit_next;
            live_reg      <= live_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        h_reg          <= h_next;
        last_reg       <= last_next;
        full_reg       <= full_next;
        pos_reg        <= pos_next;
        mov_reg        <= mov_next;
        ent_reg        <= ent_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        res_dpos_reg   <= res_dpos_next;
        res_mfrom_reg  <= res_mfrom_next;
        res_live_reg   <= res_live_next;
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_handle_reg <= res_handle_reg;
            out_dpos_reg   <= res_dpos_reg;
            out_mfrom_reg  <= res_mfrom_reg;
            out_live_reg   <= res_live_reg;
            out_total_reg  <= live_reg;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.handle_out     = out_handle_reg;
    assign rsp.dense_position = out_dpos_reg;
    assign rsp.moved_from     = out_mfrom_reg;
    assign rsp.is_live        = out_live_reg;
    assign rsp.live_total     = out_total_reg;

    logic table_full;
    logic tail_clash;
    logic full_bad;

    assign table_full = (live_reg == CAP_C);
    assign tail_clash = (state_reg == S_MOV) && slot_we && !full_reg
                        && (slot_waddr == slot_raddr);
    assign full_bad   = rsp.valid && (rsp.status == ght_pkg::ST_FULL)
                        && (rsp.live_total != CAP_C);

    `ASSERT_ALWAYS(a_live_bound, clk, rst_n, live_reg <= CAP_C, "live count above capacity")

    `ASSERT_IMPLIES(a_head_end_full, clk, rst_n, head_reg[IDX_W], table_full, "list end early")

    `ASSERT_ALWAYS(a_mov_no_clash, clk, rst_n, !tail_clash, "moved slot collides with tail")

    `ASSERT_ALWAYS(a_full_total, clk, rst_n, !full_bad, "full status with table not full")

endmodule

`default_nettype wire

>>> dv/tb_generational_handle_table.sv
// ----------------------------------------------------------------------------
// tb_generational_handle_table
// Self-checking bench for the generational handle table. A directed table
// covers reset state, stale handles, the swap on remove and clear. Random
// blocks of add, remove, lookup and rare clear commands follow. Every result
// is compared with its typed row or a local slot map kept in step with requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_generational_handle_table;

    import ght_pkg::*;

    localparam int IB = SLOT_INDEX_BITS_DEF;
    localparam int CAP = 1 << IB;
    localparam logic [31:0] GEN_INC = 32'(CAP);
    localparam logic [IB:0] NO_ENTRY = (IB + 1)'(CAP);
    localparam int unsigned RUN_LIMIT = 3_000_000;
    localparam int unsigned RANDOM_BLOCKS = 15;
    localparam int unsigned BLOCK_ITEMS = 100;

    typedef logic [CMD_W-1:0] cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [31:0]         handle;
        logic [IB-1:0]       dense_pos;
        logic [IB-1:0]       moved_from;
        logic                live;
        logic [IB:0]         total;
    } table_result_t;

    typedef struct packed {
        cmd_t          cmd;
        logic [31:0]   handle;
        bit            typed;
        table_result_t want;
    } directed_row_t;

    // Rows with typed=1 carry the result as read straight off the spec.
    localparam directed_row_t DIRECTED_ROWS [21] = '{
        '{CMD_LOOKUP, 32'h0000_0000, 1'b1, '{ST_DEAD, 32'h0000_0000, 0, 0, 1'b0, 0}},
        '{CMD_REMOVE, 32'hFFFF_FFFF, 1'b1, '{ST_DEAD, 32'hFFFF_FFFF, 0, 0, 1'b0, 0}},
        '{CMD_ADD,    32'hFFFF_FFFF, 1'b1, '{ST_OK,   32'h0000_1000, 0, 0, 1'b0, 1}},
        '{CMD_ADD,    32'h0000_0000, 1'b1, '{ST_OK,   32'h0000_1001, 1, 0, 1'b0, 2}},
        '{CMD_ADD,    32'h5A5A_5A5A, 1'b1, '{ST_OK,   32'h0000_1002, 2, 0, 1'b0, 3}},
        '{CMD_LOOKUP, 32'h0000_1001, 1'b1, '{ST_OK,   32'h0000_1001, 1, 0, 1'b1, 3}},
        '{CMD_LOOKUP, 32'h0000_0001, 1'b1, '{ST_DEAD, 32'h0000_0001, 0, 0, 1'b0, 3}},
        '{CMD_REMOVE, 32'h0000_1000, 1'b1, '{ST_OK,   32'h0000_1000, 0, 2, 1'b0, 2}},
        '{CMD_LOOKUP, 32'h0000_1002, 1'b0, '0},
        '{CMD_REMOVE, 32'h0000_1000, 1'b1, '{ST_DEAD, 32'h0000_1000, 0, 0, 1'b0, 2}},
        '{CMD_REMOVE, 32'h0000_1002, 1'b0, '0},
        '{CMD_REMOVE, 32'h0000_1001, 1'b0, '0},
        '{CMD_ADD,    32'h0000_0000, 1'b0, '0},
        '{CMD_LOOKUP, 32'hFFFF_FFFF, 1'b1, '{ST_DEAD, 32'hFFFF_FFFF, 0, 0, 1'b0, 1}},
        '{CMD_LOOKUP, 32'hFFFF_F003, 1'b0, '0},
        '{CMD_CLEAR,  32'hA5A5_A5A5, 1'b1, '{ST_OK,   32'hA5A5_A5A5, 0, 0, 1'b0, 0}},
        '{CMD_LOOKUP, 32'h0000_1003, 1'b1, '{ST_DEAD, 32'h0000_1003, 0, 0, 1'b0, 0}},
        '{CMD_ADD,    32'h0000_0000, 1'b1, '{ST_OK,   32'h0000_1000, 0, 0, 1'b0, 1}},
        '{CMD_REMOVE, 32'h0000_1000, 1'b1, '{ST_OK,   32'h0000_1000, 0, 0, 1'b0, 0}},
        '{CMD_ADD,    32'h0000_0000, 1'b0, '0},
        '{CMD_CLEAR,  32'h0000_0000, 1'b1, '{ST_OK,   32'h0000_0000, 0, 0, 1'b0, 0}}
    };

    logic clk = 1'b0;
    logic rst_n;

    ght_req_if cmd_bus ();
    ght_rsp_if #(.SLOT_INDEX_BITS(IB)) result_bus ();

    generational_handle_table #(
        .SLOT_INDEX_BITS(IB)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cmd_bus),
        .rsp   (result_bus)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Shadow slot map
    logic [31:0] slot_hdl  [CAP];
    logic [IB:0] slot_pos  [CAP];
    logic [IB:0] slot_next [CAP];
    logic [31:0] dense_hdl [CAP];
    logic [IB:0] live_cnt;
    logic [IB:0] free_head;
    logic [IB-1:0] free_tail;

    table_result_t pending_results [$];
    logic [31:0]   retired_handles [$];

    int unsigned errors = 0;
    int unsigned results_checked = 0;
    int unsigned cmd_seen [4];
    int unsigned full_adds = 0;
    int unsigned rejected_handles = 0;
    int unsigned peak_live = 0;
    int unsigned cycle_count = 0;
    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;

    function automatic void reset_table();
        for (int i = 0; i < CAP; i++)
        begin
            slot_hdl[i]  = 32'(i);
            slot_pos[i]  = NO_ENTRY;
            slot_next[i] = (IB + 1)'(i + 1);
            dense_hdl[i] = '0;
        end
        live_cnt  = '0;
        free_head = '0;
        free_tail = '1;
    endfunction

    function automatic bit handle_is_live(logic [31:0] h);
        logic [IB-1:0] s;
        s = h[IB-1:0];
        return slot_hdl[s] == h && !slot_pos[s][IB];
    endfunction

    function automatic table_result_t apply_command(cmd_t c, logic [31:0] h);
        table_result_t r;
        logic [IB-1:0] s;
        logic [IB-1:0] p;
        logic [IB-1:0] last;
        logic [31:0]   moved;
        r = '0;
        r.handle = h;
        case (c)
            CMD_ADD:
            begin
                if (live_cnt[IB])
                begin
                    r.status = ST_FULL;
                    r.handle = '0;
                end
                else
                begin
                    s = free_head[IB-1:0];
                    p = live_cnt[IB-1:0];
                    free_head = slot_next[s];
                    slot_hdl[s] = slot_hdl[s] + GEN_INC;
                    slot_pos[s] = {1'b0, p};
                    dense_hdl[p] = slot_hdl[s];
                    live_cnt = live_cnt + 1'b1;
                    r.handle = slot_hdl[s];
                    r.dense_pos = p;
                end
            end
            CMD_REMOVE:
            begin
                if (!handle_is_live(h))
                    r.status = ST_DEAD;
                else
                begin
                    s = h[IB-1:0];
                    p = slot_pos[s][IB-1:0];
                    last = IB'(live_cnt - 1'b1);
                    moved = dense_hdl[last];
                    // fill the gap with the last live entry
                    dense_hdl[p] = moved;
                    slot_pos[moved[IB-1:0]] = {1'b0, p};
                    slot_pos[s] = NO_ENTRY;
                    slot_next[s] = NO_ENTRY;
                    // a full table has no free list to append to
                    if (live_cnt[IB])
                        free_head = {1'b0, s};
                    else
                        slot_next[free_tail] = {1'b0, s};
                    free_tail = s;
                    live_cnt = live_cnt - 1'b1;
                    r.dense_pos = p;
                    r.moved_from = last;
                end
            end
            CMD_LOOKUP:
            begin
                if (handle_is_live(h))
                begin
                    r.live = 1'b1;
                    r.dense_pos = slot_pos[h[IB-1:0]][IB-1:0];
                end
                else
                    r.status = ST_DEAD;
            end
            default:
                reset_table();
        endcase
        r.total = live_cnt;
        return r;
    endfunction

    function automatic void retire_handle(logic [31:0] h);
        retired_handles.push_back(h);
        if (retired_handles.size() > 64)
            retired_handles.delete($urandom_range(0, 63));
    endfunction

    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // Mostly live handles, then retired ones, then near misses and noise.
    function automatic logic [31:0] choose_handle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (live_cnt != 0 && r < 65)
            return dense_hdl[$urandom_range(0, int'(live_cnt) - 1)];
        if (retired_handles.size() != 0 && r < 88)
            return retired_handles[$urandom_range(0, retired_handles.size() - 1)];
        if (r < 94)
            return slot_hdl[$urandom_range(0, CAP - 1)];
        return $urandom();
    endfunction

    function automatic cmd_t choose_command(int unsigned add_pct);
        int unsigned r;
        if ($urandom_range(0, 999) < 4)
            return CMD_CLEAR;
        r = $urandom_range(0, 99);
        if (r < add_pct)
            return CMD_ADD;
        if (r < add_pct + (100 - add_pct) / 2)
            return CMD_REMOVE;
        return CMD_LOOKUP;
    endfunction

    // Called and returns at a falling edge; valid stays high for a following transfer.
    task automatic send_command(input cmd_t c, input logic [31:0] h, input bit typed,
                                input table_result_t typed_want);
        table_result_t predicted;
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (pick_gap()) @(negedge clk);
        end
        cmd_bus.valid <= 1'b1;
        cmd_bus.command <= c;
        cmd_bus.handle_in <= h;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
        if (c == CMD_CLEAR)
            for (int i = 0; i < 4 && i < int'(live_cnt); i++)
                retire_handle(dense_hdl[i]);
        predicted = apply_command(c, h);
        if (c == CMD_REMOVE && predicted.status == ST_OK)
            retire_handle(h);
        if (predicted.status == ST_FULL)
            full_adds++;
        if (predicted.status == ST_DEAD)
            rejected_handles++;
        if (int'(live_cnt) > peak_live)
            peak_live = 32'(live_cnt);
        cmd_seen[c]++;
        pending_results.push_back(typed ? typed_want : predicted);
        @(negedge clk);
    endtask

    // Hold the sender until every outstanding result has come back.
    task automatic wait_drain();
        cmd_bus.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0);
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("[%0t] %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        table_result_t got;
        table_result_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            got.status     = result_bus.status;
            got.handle     = result_bus.handle_out;
            got.dense_pos  = result_bus.dense_position;
            got.moved_from = result_bus.moved_from;
            got.live       = result_bus.is_live;
            got.total      = result_bus.live_total;
            if (pending_results.size() == 0)
            begin
                $display("[%0t] result with none pending: status %0d handle 0x%0h",
                         $time, got.status, got.handle);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("handle_out", want.handle, got.handle);
                check_field("dense_position", 32'(want.dense_pos), 32'(got.dense_pos));
                check_field("moved_from", 32'(want.moved_from), 32'(got.moved_from));
                check_field("is_live", 32'(want.live), 32'(got.live));
                check_field("live_total", 32'(want.total), 32'(got.total));
                results_checked++;
            end
        end
    end

    // Result side back-pressure
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left != 0)
            begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct)
            begin
                hold_left = pick_gap() - 1;
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        while (cycle_count < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int unsigned add_pct;
        rst_n = 1'b0;
        cmd_bus.valid = 1'b0;
        cmd_bus.command = CMD_ADD;
        cmd_bus.handle_in = '0;
        foreach (cmd_seen[i])
            cmd_seen[i] = 0;
        reset_table();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        snk_idle_pct = 20;
        foreach (DIRECTED_ROWS[i])
            send_command(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].handle,
                         DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        wait_drain();

        src_idle_pct = 5;
        snk_idle_pct = 5;
        send_command(CMD_CLEAR, $urandom(), 1'b0, '0);

        for (int blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            case ($urandom_range(0, 2))
                0: add_pct = 25;
                1: add_pct = 45;
                default: add_pct = 60;
            endcase
            case ($urandom_range(0, 2))
                0: src_idle_pct = 0;
                1: src_idle_pct = 15;
                default: src_idle_pct = 40;
            endcase
            case ($urandom_range(0, 2))
                0: snk_idle_pct = 0;
                1: snk_idle_pct = 15;
                default: snk_idle_pct = 40;
            endcase
            repeat (BLOCK_ITEMS) send_command(choose_command(add_pct), choose_handle(), 1'b0, '0);
            if (blk % 4 == 3)
                wait_drain();
        end

        wait_drain();
        repeat (64) @(negedge clk);

        $display("Covered %0d adds, %0d removes, %0d lookups, %0d clears; %0d results checked.",
                 cmd_seen[CMD_ADD], cmd_seen[CMD_REMOVE], cmd_seen[CMD_LOOKUP],
                 cmd_seen[CMD_CLEAR], results_checked);
        $display("Peak occupancy %0d of %0d, %0d adds on a full table, %0d dead handles.",
                 peak_live, CAP, full_adds, rejected_handles);
        if (errors == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
